FILE: rtl/c3mv_pkg.sv
// Shared types, constants and helper functions for the complex 3x3
// matrix-vector multiplier. Depends on nothing; every rtl file imports it.
package c3mv_pkg;

    typedef struct packed {
        logic [63:0] mat_00;
        logic [63:0] mat_01;
        logic [63:0] mat_02;
        logic [63:0] mat_10;
        logic [63:0] mat_11;
        logic [63:0] mat_12;
        logic [63:0] mat_20;
        logic [63:0] mat_21;
        logic [63:0] mat_22;
        logic [63:0] vec_0;
        logic [63:0] vec_1;
        logic [63:0] vec_2;
    } in_item_t;

    typedef struct packed {
        logic [63:0] res_0;
        logic [63:0] res_1;
        logic [63:0] res_2;
    } out_item_t;

    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam int          MulStages = 3;
    localparam int          AddStages = 3;
    localparam int          NumTerms  = 6;
    localparam int          Latency   = MulStages + (NumTerms - 1) * AddStages;

    // Leading zero count of a 48-bit word; 48 for an all-zero word.
    function automatic logic [5:0] lzc48(input logic [47:0] w);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (w[i]) begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

    // Leading zero count of a 27-bit word; 27 for an all-zero word.
    function automatic logic [4:0] lzc27(input logic [26:0] w);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (w[i]) begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

    function automatic logic bad_nan(input logic [31:0] w);
        return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0) && (w != QNAN);
    endfunction

endpackage

FILE: rtl/c3mv_fmul.sv
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// Depends on c3mv_pkg for the leading zero count and the NaN constant.
module c3mv_fmul import c3mv_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);

    // Stage 1: unpack and multiply the significands.
    logic [7:0]  a_exp, b_exp;
    logic [23:0] a_man, b_man;
    logic [8:0]  a_eff, b_eff;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic [47:0] prd_reg;
    logic [8:0]  esum_reg;
    logic        sgn1_reg, nan1_reg, inf1_reg, zero1_reg;

    always_comb begin
        a_exp  = a[30:23];
        b_exp  = b[30:23];
        a_man  = {a_exp != 8'd0, a[22:0]};
        b_man  = {b_exp != 8'd0, b[22:0]};
        a_eff  = (a_exp == 8'd0) ? 9'd1 : {1'b0, a_exp};
        b_eff  = (b_exp == 8'd0) ? 9'd1 : {1'b0, b_exp};
        a_nan  = (a_exp == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b_exp == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a_exp == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b_exp == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prd_reg   <= a_man * b_man;
            esum_reg  <= a_eff + b_eff;
            sgn1_reg  <= a[31] ^ b[31];
            nan1_reg  <= a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
            inf1_reg  <= a_inf || b_inf;
            zero1_reg <= a_zero || b_zero;
        end
    end

    // Stage 2: bring the leading one of the product to the top bit.
    logic [5:0]         lz;
    logic [47:0]        nrm_next;
    logic signed [9:0]  enorm_next;

    logic [47:0]        nrm_reg;
    logic signed [9:0]  enorm_reg;
    logic               sgn2_reg, nan2_reg, inf2_reg, zero2_reg;

    always_comb begin
        lz         = lzc48(prd_reg);
        nrm_next   = prd_reg << lz;
        enorm_next = $signed({1'b0, esum_reg}) - 10'sd126 - $signed({4'd0, lz});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nrm_reg   <= nrm_next;
            enorm_reg <= enorm_next;
            sgn2_reg  <= sgn1_reg;
            nan2_reg  <= nan1_reg;
            inf2_reg  <= inf1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Stage 3: shift into the subnormal range if needed, round and pack.
    logic signed [9:0] dsh_full, e_base, e_fin;
    logic [5:0]        dsh;
    logic [47:0]       q;
    logic              sticky, rnd;
    logic [24:0]       mr;
    logic [23:0]       m_fin;
    logic [31:0]       p_next;
    logic [31:0]       p_reg;

    always_comb begin
        dsh_full = (enorm_reg < 10'sd1) ? (10'sd1 - enorm_reg) : 10'sd0;
        dsh      = (dsh_full > 10'sd49) ? 6'd49 : dsh_full[5:0];
        e_base   = (enorm_reg < 10'sd1) ? 10'sd1 : enorm_reg;
        q        = nrm_reg >> dsh;
        sticky   = ((q << dsh) != nrm_reg) || (q[22:0] != 23'd0);
        rnd      = q[23] && (sticky || q[24]);
        mr       = {1'b0, q[47:24]} + {24'd0, rnd};
        if (mr[24]) begin
            m_fin = mr[24:1];
            e_fin = e_base + 10'sd1;
        end else begin
            m_fin = mr[23:0];
            e_fin = e_base;
        end
        if (nan2_reg) begin
            p_next = QNAN;
        end else if (inf2_reg || (!zero2_reg && e_fin >= 10'sd255)) begin
            p_next = {sgn2_reg, 8'hFF, 23'd0};
        end else if (zero2_reg) begin
            p_next = {sgn2_reg, 31'd0};
        end else begin
            p_next = {sgn2_reg, (m_fin[23] ? e_fin[7:0] : 8'd0), m_fin[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/c3mv_fadd.sv
// Three-stage IEEE single adder, round to nearest even, subnormals kept.
// Depends on c3mv_pkg for the leading zero count and the NaN constant.
module c3mv_fadd import c3mv_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] s
);

    // Stage 1: order by magnitude and align the smaller operand.
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [4:0]  dcl;
    logic [26:0] mx, my, my_sh;
    logic        a_nan, b_nan, a_inf, b_inf;

    logic [26:0] mx_reg, my_reg;
    logic [7:0]  ex1_reg;
    logic        sx1_reg, sub1_reg, zs1_reg, nan1_reg, inf1_reg;

    always_comb begin
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx    = {x[30:23] != 8'd0, x[22:0], 3'b000};
        my    = {y[30:23] != 8'd0, y[22:0], 3'b000};
        d     = ex - ey;
        dcl   = (d > 8'd27) ? 5'd27 : d[4:0];
        my_sh = my >> dcl;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg   <= mx;
            my_reg   <= {my_sh[26:1], my_sh[0] | ((my_sh << dcl) != my)};
            ex1_reg  <= ex;
            sx1_reg  <= x[31];
            sub1_reg <= x[31] ^ y[31];
            zs1_reg  <= x[31] & y[31];
            nan1_reg <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
            inf1_reg <= a_inf || b_inf;
        end
    end

    // Stage 2: add or subtract the aligned significands.
    logic [27:0] sum_reg;
    logic [7:0]  ex2_reg;
    logic        sx2_reg, zs2_reg, nan2_reg, inf2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sub1_reg ? ({1'b0, mx_reg} - {1'b0, my_reg})
                                 : ({1'b0, mx_reg} + {1'b0, my_reg});
            ex2_reg  <= ex1_reg;
            sx2_reg  <= sx1_reg;
            zs2_reg  <= zs1_reg;
            nan2_reg <= nan1_reg;
            inf2_reg <= inf1_reg;
        end
    end

    // Stage 3: normalize without going below the smallest exponent, round.
    logic [4:0]  lz, shl;
    logic [7:0]  emax_shl;
    logic [26:0] n;
    logic [9:0]  e_n, e_fin;
    logic        rnd;
    logic [24:0] mr;
    logic [23:0] m_fin;
    logic [31:0] s_next;
    logic [31:0] s_reg;

    always_comb begin
        lz       = lzc27(sum_reg[26:0]);
        emax_shl = ex2_reg - 8'd1;
        shl      = ({3'd0, lz} > emax_shl) ? emax_shl[4:0] : lz;
        if (sum_reg[27]) begin
            n   = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            e_n = {2'd0, ex2_reg} + 10'd1;
        end else begin
            n   = sum_reg[26:0] << shl;
            e_n = {2'd0, ex2_reg} - {5'd0, shl};
        end
        rnd = n[2] && (n[1] || n[0] || n[3]);
        mr  = {1'b0, n[26:3]} + {24'd0, rnd};
        if (mr[24]) begin
            m_fin = mr[24:1];
            e_fin = e_n + 10'd1;
        end else begin
            m_fin = mr[23:0];
            e_fin = e_n;
        end
        if (nan2_reg) begin
            s_next = QNAN;
        end else if (inf2_reg || e_fin >= 10'd255) begin
            s_next = {sx2_reg, 8'hFF, 23'd0};
        end else if (sum_reg == 28'd0) begin
            // Exact cancellation gives +0 unless both operands were negative.
            s_next = {zs2_reg, 31'd0};
        end else begin
            s_next = {sx2_reg, (m_fin[23] ? e_fin[7:0] : 8'd0), m_fin[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule

FILE: rtl/complex_3x3_matrix_vector_multiply_top.sv
// An accepted request passes through 3 multiply stages, then five chained
// 3-stage adds per output part, before its result is offered.
// Throughput: one request per cycle; 36 multipliers and 30 adders all run in
// parallel, and the whole pipeline holds while a result waits to be taken.
// Reset (aresetn, synchronous, active low) clears the valid pipeline and the
// adjoint mode bit; data registers are not reset.
module complex_3x3_matrix_vector_multiply_top import c3mv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                adj_reg;
    logic [Latency-1:0]  vld_reg;
    logic                en;
    logic [63:0]         mat [9];
    logic [63:0]         vec [3];
    logic [31:0]         prod [6][6];
    logic [31:0]         acc  [6][6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            adj_reg <= cfg_wr_data;
        end
    end

    assign en      = !vld_reg[Latency-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[Latency-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Latency-2:0], s_valid};
        end
    end

    assign mat[0] = s_data.mat_00;
    assign mat[1] = s_data.mat_01;
    assign mat[2] = s_data.mat_02;
    assign mat[3] = s_data.mat_10;
    assign mat[4] = s_data.mat_11;
    assign mat[5] = s_data.mat_12;
    assign mat[6] = s_data.mat_20;
    assign mat[7] = s_data.mat_21;
    assign mat[8] = s_data.mat_22;
    assign vec[0] = s_data.vec_0;
    assign vec[1] = s_data.vec_1;
    assign vec[2] = s_data.vec_2;

    // Part p is output element p/2, real for even p and imaginary for odd p.
    // Term k uses column k/2; odd terms carry the imaginary matrix part, whose
    // sign is flipped up front where needed so that every accumulation step is an add.
    for (genvar p = 0; p < 6; p++) begin : g_part
        localparam int I  = p / 2;
        localparam int IM = p % 2;
        for (genvar k = 0; k < NumTerms; k++) begin : g_term
            localparam int J   = k / 2;
            localparam int SEC = k % 2;
            logic [63:0] e;
            logic [31:0] op_a, op_b;

            always_comb begin
                e = adj_reg ? mat[J*3 + I] : mat[I*3 + J];
                if (SEC == 0) begin
                    op_a = e[63:32];
                    op_b = (IM == 0) ? vec[J][63:32] : vec[J][31:0];
                end else begin
                    op_a = {e[31] ^ ((IM == 0) ? !adj_reg : adj_reg), e[30:0]};
                    op_b = (IM == 0) ? vec[J][31:0] : vec[J][63:32];
                end
            end

            c3mv_fmul u_mul (
                .aclk (aclk),
                .en   (en),
                .a    (op_a),
                .b    (op_b),
                .p    (prod[p][k])
            );

            if (k == 0) begin : g_first
                assign acc[p][0] = prod[p][0];
            end else if (k == 1) begin : g_direct
                c3mv_fadd u_add (
                    .aclk (aclk),
                    .en   (en),
                    .a    (acc[p][0]),
                    .b    (prod[p][1]),
                    .s    (acc[p][1])
                );
            end else begin : g_delayed
                localparam int D = AddStages * (k - 1);
                logic [31:0] dl_reg [D];

                always_ff @(posedge aclk) begin
                    if (en) begin
                        dl_reg[0] <= prod[p][k];
                        for (int n = 1; n < D; n++) begin
                            dl_reg[n] <= dl_reg[n-1];
                        end
                    end
                end

                c3mv_fadd u_add (
                    .aclk (aclk),
                    .en   (en),
                    .a    (acc[p][k-1]),
                    .b    (dl_reg[D-1]),
                    .s    (acc[p][k])
                );
            end
        end
    end

    assign m_data.res_0 = {acc[0][NumTerms-1], acc[1][NumTerms-1]};
    assign m_data.res_1 = {acc[2][NumTerms-1], acc[3][NumTerms-1]};
    assign m_data.res_2 = {acc[4][NumTerms-1], acc[5][NumTerms-1]};

`ifndef SYNTH
    a_canon_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !bad_nan(m_data.res_0[63:32]) && !bad_nan(m_data.res_0[31:0])
                 && !bad_nan(m_data.res_1[63:32]) && !bad_nan(m_data.res_1[31:0])
                 && !bad_nan(m_data.res_2[63:32]) && !bad_nan(m_data.res_2[31:0]))
        else $error("result carries a non-canonical NaN");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid pipeline moved during a stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request missing from first stage");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !adj_reg)
        else $error("reset did not clear valid pipeline or mode");
`endif

endmodule

FILE: verif/c3mv_checker.sv
`timescale 1ns / 1ps
// Checker for the complex 3x3 matrix-vector multiplier: watches both channels,
// predicts each product in single precision and compares. Depends on c3mv_pkg.
module c3mv_checker import c3mv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending
);

    out_item_t expected_products[$];
    logic      adjoint_mode;

    // Widens a single float to a double; exact for every value.
    function automatic real single_to_real(input logic [31:0] w);
        logic [63:0] d;
        logic [23:0] mant;
        int          ex;
        d = {w[31], 63'd0};
        if (w[30:23] == 8'hFF) begin
            d[62:52] = 11'h7FF;
            d[51:0]  = {w[22:0], 29'd0};
        end else if (w[30:23] != 8'd0) begin
            d[62:52] = 11'(int'(w[30:23]) - 127 + 1023);
            d[51:0]  = {w[22:0], 29'd0};
        end else if (w[22:0] != 23'd0) begin
            mant = {1'b0, w[22:0]};
            ex   = -126;
            while (!mant[23]) begin
                mant = mant << 1;
                ex   = ex - 1;
            end
            d[62:52] = 11'(ex + 1023);
            d[51:0]  = {mant[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // Rounds a double to the nearest even single, subnormals included.
    function automatic logic [31:0] real_to_single(input real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          ex;
        int          sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 52'd0) ? QNAN : {d[63], 8'hFF, 23'd0};
        end
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        ex  = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        if (ex > 127) begin
            return {d[63], 8'hFF, 23'd0};
        end
        sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 60) begin
            sh = 60;
        end
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) begin
            kept = kept + 64'd1;
        end
        if (ex < -126) begin
            return {d[63], kept[30:0]};
        end
        if (kept[24]) begin
            kept = kept >> 1;
            ex   = ex + 1;
        end
        if (ex > 127) begin
            return {d[63], 8'hFF, 23'd0};
        end
        return {d[63], 8'(ex + 127), kept[22:0]};
    endfunction

    function automatic real rnd(input real x);
        return single_to_real(real_to_single(x));
    endfunction

    function automatic out_item_t predict_product(input in_item_t it, input logic adj);
        logic [63:0] mat [9];
        logic [63:0] vec [3];
        logic [63:0] res [3];
        logic [63:0] e;
        real         er, ei, br, bi, re, im;
        out_item_t   r;
        mat = '{it.mat_00, it.mat_01, it.mat_02, it.mat_10, it.mat_11, it.mat_12,
                it.mat_20, it.mat_21, it.mat_22};
        vec = '{it.vec_0, it.vec_1, it.vec_2};
        for (int i = 0; i < 3; i++) begin
            re = 0.0;
            im = 0.0;
            for (int j = 0; j < 3; j++) begin
                e  = adj ? mat[j * 3 + i] : mat[i * 3 + j];
                er = single_to_real(e[63:32]);
                ei = single_to_real(e[31:0]);
                br = single_to_real(vec[j][63:32]);
                bi = single_to_real(vec[j][31:0]);
                if (j == 0) begin
                    re = rnd(er * br);
                    im = rnd(er * bi);
                end else begin
                    re = rnd(re + rnd(er * br));
                    im = rnd(im + rnd(er * bi));
                end
                if (adj) begin
                    re = rnd(re + rnd(ei * bi));
                    im = rnd(im - rnd(ei * br));
                end else begin
                    re = rnd(re - rnd(ei * bi));
                    im = rnd(im + rnd(ei * br));
                end
            end
            res[i] = {real_to_single(re), real_to_single(im)};
        end
        r.res_0 = res[0];
        r.res_1 = res[1];
        r.res_2 = res[2];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    assign pending = expected_products.size();

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            adjoint_mode <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                adjoint_mode <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_products.push_back(predict_product(s_data, adjoint_mode));
            end
            if (m_valid && m_ready) begin
                if (expected_products.size() == 0) begin
                    $display("%0t: result with no request outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = expected_products.pop_front();
                    if (m_data.res_0 !== want.res_0) begin
                        report_mismatch("res_0", m_data.res_0, want.res_0);
                    end
                    if (m_data.res_1 !== want.res_1) begin
                        report_mismatch("res_1", m_data.res_1, want.res_1);
                    end
                    if (m_data.res_2 !== want.res_2) begin
                        report_mismatch("res_2", m_data.res_2, want.res_2);
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb_complex_3x3_matrix_vector_multiply_top.sv
`timescale 1ns / 1ps
// Testbench top for the complex 3x3 matrix-vector multiplier: clock, reset,
// stimulus and verdict. Depends on c3mv_pkg, c3mv_checker and the block.
module tb_complex_3x3_matrix_vector_multiply_top;
    import c3mv_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles    = 400;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_wr_en;
    logic      cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_seq;
    int        hold_seen;
    int        hold_cnt;
    int        quiet_cycles;

    always #5 aclk = ~aclk;

    complex_3x3_matrix_vector_multiply_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    c3mv_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0: w = {w[31], 31'd0};
            1: w = {w[31], 8'hFF, 23'd0};
            2: w = {w[31], 8'd0, w[22:0]};
            3: w = {w[31], 8'hFF, w[22:0] | 23'd1};
            4, 5, 6, 7: w[30:23] = 8'($urandom_range(134, 120));
            default: ;
        endcase
        return w;
    endfunction

    function automatic in_item_t rand_request();
        in_item_t it;
        logic [63:0] f [12];
        for (int k = 0; k < 12; k++) begin
            f[k] = {rand_float(), rand_float()};
        end
        it = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
        return it;
    endfunction

    // Fills every field of a request with one packed complex value.
    function automatic in_item_t flat_request(input logic [63:0] v);
        return {12{v}};
    endfunction

    task automatic send_request(input in_item_t it);
        logic accepted;
        // Each cycle the sender stays idle with the given chance.
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(negedge aclk);
            accepted = s_ready;
            @(posedge aclk);
        end while (!accepted);
    endtask

    task automatic drain_and_write(input logic mode);
        s_valid <= 1'b0;
        // Let the checker log the last accepted request before watching pending.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic directed_requests();
        in_item_t it;
        send_request(flat_request(64'd0));
        send_request(flat_request({2{32'h8000_0000}}));
        send_request(flat_request('1));
        send_request(flat_request({2{32'h7F7F_FFFF}}));
        send_request(flat_request({32'h0000_0001, 32'h8000_0001}));
        send_request(flat_request({32'h0080_0000, 32'h3F00_0000}));
        send_request(flat_request({32'h7F80_0000, 32'hFF80_0000}));
        send_request(flat_request({32'h7FA0_0000, 32'h3F80_0000}));
        // Diagonal matrix of 1, 1 and i, so each result uses one vector element.
        it = '0;
        it.mat_00 = {32'h3F80_0000, 32'd0};
        it.mat_11 = {32'h3F80_0000, 32'd0};
        it.mat_22 = {32'd0, 32'h3F80_0000};
        it.vec_0  = {32'h4040_0000, 32'hC000_0000};
        it.vec_1  = {32'h0000_0003, 32'h7F80_0000};
        it.vec_2  = {32'h3DCC_CCCD, 32'hBF80_0000};
        send_request(it);
        // Infinity times zero and infinity minus infinity both give NaN.
        it = flat_request({32'h3F80_0000, 32'h3F80_0000});
        it.mat_00 = {32'h7F80_0000, 32'd0};
        it.mat_01 = {32'hFF80_0000, 32'h7F80_0000};
        it.vec_0  = {32'h3F80_0000, 32'd0};
        send_request(it);
        // Terms that cancel to an exact zero, and a large sum that overflows.
        it = flat_request({32'h3F80_0000, 32'h3F80_0000});
        it.vec_1 = {32'hBF80_0000, 32'hBF80_0000};
        it.vec_2 = {32'h7F7F_FFFF, 32'h7F7F_FFFF};
        send_request(it);
        send_request(flat_request({32'h0080_0001, 32'h0000_7FFF}));
    endtask

    task automatic random_requests(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3) begin
                hold_seq = hold_seq + 1;
            end
            send_request(rand_request());
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_seq       = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 88;
        drain_and_write(1'b0);
        directed_requests();
        drain_and_write(1'b1);
        directed_requests();
        random_requests(140, 1'b0);

        send_idle_pct = 88;
        recv_idle_pct = 21;
        drain_and_write(1'b0);
        random_requests(140, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_and_write(1'b1);
        random_requests(150, 1'b1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: complex_3x3_matrix_vector_multiply_top.f
rtl/c3mv_pkg.sv
rtl/c3mv_fmul.sv
rtl/c3mv_fadd.sv
rtl/complex_3x3_matrix_vector_multiply_top.sv
verif/c3mv_checker.sv
verif/tb_complex_3x3_matrix_vector_multiply_top.sv
